// ===== src/tta_pkg.sv =====
// Shared types, constants and helpers for the tensor transpose address generator.
// Used by the interfaces and by every module of the block; depends on nothing.
package tta_pkg;

    localparam int DIMS_MAX_DEF  = 4;
    localparam int OFS_BITS_DEF  = 16;
    localparam int IDX_W         = 16;
    localparam int EXT_W         = 17;
    localparam int NUM_SIZE_REGS = 4;
    localparam int MAP_W         = 3;
    localparam int ND_W          = 3;
    localparam int LMAP_W        = 8;
    localparam int DEST_W        = 16;
    localparam int ELEM_W        = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 17;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [EXT_W-1:0]  MAX_EXTENT    = 17'h1_0000;
    localparam logic [ND_W-1:0]   RST_NUM_DIMS  = 3'd1;
    localparam logic [EXT_W-1:0]  RST_SIZE      = 17'd1;
    localparam logic [LMAP_W-1:0] RST_LEVEL_MAP = 8'd228;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_DIMS  = 3'd0,
        REG_SIZE_DIM0 = 3'd1,
        REG_SIZE_DIM1 = 3'd2,
        REG_SIZE_DIM2 = 3'd3,
        REG_SIZE_DIM3 = 3'd4,
        REG_LEVEL_MAP = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_stride_state;

    // Status from the configuration unit to the front end.
    typedef struct packed {
        logic            busy;
        logic            done;
        logic [ND_W-1:0] used_levels;
    } t_cfg_ctl;

    // An extent of zero acts as one, anything above the maximum acts as the maximum.
    function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] size);
        logic [EXT_W-1:0] ext;
        ext = size;
        if (size == '0) begin
            ext = EXT_W'(1);
        end else if (size > MAX_EXTENT) begin
            ext = MAX_EXTENT;
        end
        return ext;
    endfunction

endpackage

// ===== src/tta_if.sv =====
// Valid/ready channel interfaces of the tensor transpose address generator.
// Depends on tta_pkg for the payload widths.
interface tta_elem_if;
    import tta_pkg::*;
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] elem_real;
    logic [ELEM_W-1:0] elem_imag;
    modport source (output valid, elem_real, elem_imag, input ready);
    modport sink   (input valid, elem_real, elem_imag, output ready);
endinterface

interface tta_res_if;
    import tta_pkg::*;
    logic              valid;
    logic              ready;
    logic [DEST_W-1:0] dest_offset;
    logic [ELEM_W-1:0] out_real;
    logic [ELEM_W-1:0] out_imag;
    logic              last_elem;
    modport source (output valid, dest_offset, out_real, out_imag, last_elem, input ready);
    modport sink   (input valid, dest_offset, out_real, out_imag, last_elem, output ready);
endinterface

interface tta_cfg_if;
    import tta_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/tta_cfg.sv =====
// Configuration registers and the sequential stride unit of the transpose address generator.
// Depends on tta_pkg and tta_cfg_if.
module tta_cfg #(
    parameter int MAX_DIMS    = tta_pkg::DIMS_MAX_DEF,
    parameter int OFFSET_BITS = tta_pkg::OFS_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    tta_cfg_if.sink                                   i_cfg,
    output tta_pkg::t_cfg_ctl                         o_ctl,
    output logic [MAX_DIMS-1:0][tta_pkg::EXT_W-1:0]   o_extent,
    output logic [MAX_DIMS-1:0][OFFSET_BITS-1:0]      o_stride
);
    import tta_pkg::*;

    localparam int KW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(MAX_DIMS - 1);
    localparam int PW = OFFSET_BITS + EXT_W;

    logic [ND_W-1:0]                        r_num_dims;
    logic [NUM_SIZE_REGS-1:0][EXT_W-1:0]    r_size;
    logic [LMAP_W-1:0]                      r_level_map;

    t_stride_state                          r_state;
    logic [KW-1:0]                          r_k;
    logic [KW-1:0]                          r_m;
    logic [OFFSET_BITS-1:0]                 r_acc;
    logic                                   r_done;
    logic [MAX_DIMS-1:0][OFFSET_BITS-1:0]   r_stride;

    logic                                   w_we;
    logic [ND_W-1:0]                        w_used;
    logic [MAX_DIMS-1:0][EXT_W-1:0]         w_extent;
    logic [MAX_DIMS-1:0][MAP_W-1:0]         w_map;
    logic                                   w_use_m;
    logic [EXT_W-1:0]                       w_factor;
    logic [PW-1:0]                          w_prod;

    assign i_cfg.ready = 1'b1;
    assign w_we        = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims  <= RST_NUM_DIMS;
            r_size      <= {NUM_SIZE_REGS{RST_SIZE}};
            r_level_map <= RST_LEVEL_MAP;
        end else if (w_we) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_NUM_DIMS:  r_num_dims  <= i_cfg.data[ND_W-1:0];
                REG_SIZE_DIM0: r_size[0]   <= i_cfg.data;
                REG_SIZE_DIM1: r_size[1]   <= i_cfg.data;
                REG_SIZE_DIM2: r_size[2]   <= i_cfg.data;
                REG_SIZE_DIM3: r_size[3]   <= i_cfg.data;
                REG_LEVEL_MAP: r_level_map <= i_cfg.data[LMAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_num_dims == '0) begin
            w_used = ND_W'(1);
        end else if ({1'b0, r_num_dims} > (ND_W + 1)'(MAX_DIMS)) begin
            w_used = ND_W'(MAX_DIMS);
        end else begin
            w_used = r_num_dims;
        end
    end

    // Levels without a size register have extent one and map to themselves.
    for (genvar g = 0; g < MAX_DIMS; g++) begin : g_lvl
        if (g < NUM_SIZE_REGS) begin : g_reg
            assign w_extent[g] = clamp_extent(r_size[g]);
            assign w_map[g]    = MAP_W'(r_level_map[2*g +: 2]);
        end else begin : g_fix
            assign w_extent[g] = EXT_W'(1);
            assign w_map[g]    = MAP_W'(g);
        end
    end

    // Stride of level k is the product of the extents of the used levels
    // that map below it; one factor is folded in per cycle.
    assign w_use_m  = ({1'b0, ND_W'(r_m)} < {1'b0, w_used}) && (w_map[r_m] < w_map[r_k]);
    assign w_factor = w_use_m ? w_extent[r_m] : EXT_W'(1);
    assign w_prod   = PW'(r_acc) * PW'(w_factor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_k     <= '0;
            r_m     <= '0;
            r_acc   <= OFFSET_BITS'(1);
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (w_we) begin
                r_state <= ST_RUN;
                r_k     <= '0;
                r_m     <= '0;
                r_acc   <= OFFSET_BITS'(1);
            end else begin
                unique case (r_state)
                    ST_IDLE: ;
                    ST_RUN: begin
                        if (r_m == K_LAST) begin
                            r_acc <= OFFSET_BITS'(1);
                            r_m   <= '0;
                            if (r_k == K_LAST) begin
                                r_state <= ST_IDLE;
                                r_done  <= 1'b1;
                            end else begin
                                r_k <= r_k + KW'(1);
                            end
                        end else begin
                            r_acc <= w_prod[OFFSET_BITS-1:0];
                            r_m   <= r_m + KW'(1);
                        end
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && r_m == K_LAST && !w_we) begin
            r_stride[r_k] <= w_prod[OFFSET_BITS-1:0];
        end
    end

    assign o_ctl.busy        = (r_state == ST_RUN);
    assign o_ctl.done        = r_done;
    assign o_ctl.used_levels = w_used;
    assign o_extent          = w_extent;
    assign o_stride          = r_stride;

`ifndef SYNTHESIS
    a_write_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> o_ctl.busy)
        else $error("stride unit not busy after a register write");
    a_done_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ctl.busy) |-> o_ctl.done)
        else $error("stride unit went idle without signaling done");
`endif

endmodule

// ===== src/tta_front.sv =====
// Front end: accepts words, steps the source odometer and the per-level offset terms.
// Depends on tta_pkg, tta_elem_if and the status of tta_cfg.
module tta_front #(
    parameter int MAX_DIMS    = tta_pkg::DIMS_MAX_DEF,
    parameter int OFFSET_BITS = tta_pkg::OFS_BITS_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    tta_elem_if.sink                                              i_elem,
    input  tta_pkg::t_cfg_ctl                                     i_ctl,
    input  logic [MAX_DIMS-1:0][tta_pkg::EXT_W-1:0]               i_extent,
    input  logic [MAX_DIMS-1:0][OFFSET_BITS-1:0]                  i_stride,
    input  logic                                                  i_q_ready,
    output logic                                                  o_push,
    output logic [1+2*tta_pkg::ELEM_W+MAX_DIMS*OFFSET_BITS-1:0]   o_entry
);
    import tta_pkg::*;

    localparam int KW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam logic [KW-1:0] J_LAST = KW'(MAX_DIMS - 1);
    localparam int FW = IDX_W + OFFSET_BITS;

    logic [MAX_DIMS-1:0][IDX_W-1:0]         r_idx;
    logic [MAX_DIMS-1:0][OFFSET_BITS-1:0]   r_p;
    logic                                   r_fill;
    logic [KW-1:0]                          r_j;

    logic                                   w_accept;
    logic [MAX_DIMS-1:0]                    w_used;
    logic [MAX_DIMS-1:0]                    w_wrap;
    logic [MAX_DIMS:0]                      w_carry;
    logic [MAX_DIMS-1:0][IDX_W-1:0]         w_idx_nx;
    logic [MAX_DIMS-1:0][OFFSET_BITS-1:0]   w_p_nx;
    logic [MAX_DIMS-1:0][OFFSET_BITS-1:0]   w_p_out;
    logic                                   w_last;
    logic [FW-1:0]                          w_fill_prod;

    assign i_elem.ready = !i_ctl.busy && !i_ctl.done && !r_fill && i_q_ready;
    assign w_accept     = i_elem.valid && i_elem.ready;

    // Each term r_p[k] tracks r_idx[k] * stride[k], so an advance only adds
    // a stride or clears a term.
    always_comb begin
        w_carry[0] = 1'b1;
        w_last     = 1'b1;
        for (int k = 0; k < MAX_DIMS; k++) begin
            w_used[k]    = (k < int'(i_ctl.used_levels));
            w_wrap[k]    = ({1'b0, r_idx[k]} + EXT_W'(1)) >= i_extent[k];
            w_carry[k+1] = w_carry[k] && w_wrap[k];
            w_p_out[k]   = w_used[k] ? r_p[k] : '0;
            if (w_used[k] && !w_wrap[k]) begin
                w_last = 1'b0;
            end
            if (!w_used[k] || (w_carry[k] && w_wrap[k])) begin
                w_idx_nx[k] = '0;
                w_p_nx[k]   = '0;
            end else if (w_carry[k]) begin
                w_idx_nx[k] = r_idx[k] + IDX_W'(1);
                w_p_nx[k]   = r_p[k] + i_stride[k];
            end else begin
                w_idx_nx[k] = r_idx[k];
                w_p_nx[k]   = r_p[k];
            end
        end
    end

    assign w_fill_prod = FW'(r_idx[r_j]) * FW'(i_stride[r_j]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_p    <= '0;
            r_fill <= 1'b0;
            r_j    <= '0;
        end else if (i_ctl.busy) begin
            r_fill <= 1'b0;
        end else if (i_ctl.done) begin
            r_fill <= 1'b1;
            r_j    <= '0;
        end else if (r_fill) begin
            // Rebuild the terms from the kept index under the new strides.
            r_p[r_j] <= w_fill_prod[OFFSET_BITS-1:0];
            if (r_j == J_LAST) begin
                r_fill <= 1'b0;
            end else begin
                r_j <= r_j + KW'(1);
            end
        end else if (w_accept) begin
            r_idx <= w_idx_nx;
            r_p   <= w_p_nx;
        end
    end

    assign o_push  = w_accept;
    assign o_entry = {w_last, i_elem.elem_real, i_elem.elem_imag, w_p_out};

`ifndef SYNTHESIS
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_last |=> r_idx == '0)
        else $error("source index did not return to zero after the last word");
    a_fill_follows_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.done |=> r_fill)
        else $error("offset terms not rebuilt after new strides");
`endif

endmodule

// ===== src/tta_queue.sv =====
// Short queue between the front end and the back end of the transpose address generator.
// Depends on tta_pkg for the depth.
module tta_queue #(
    parameter int DATA_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_pop
);
    import tta_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] P_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] C_FULL = CW'(QUEUE_DEPTH);

    logic [QUEUE_DEPTH-1:0][DATA_W-1:0] r_mem;
    logic [PW-1:0]                      r_wr;
    logic [PW-1:0]                      r_rd;
    logic [CW-1:0]                      r_count;

    assign o_ready = (r_count != C_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == P_LAST) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == P_LAST) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= C_FULL) && !(i_push && !o_ready) && !(i_pop && !o_valid))
        else $error("queue pushed when full or popped when empty");
`endif

endmodule

// ===== src/tta_back.sv =====
// Back end: sums the offset terms of a queued word and holds the result register.
// Depends on tta_pkg and tta_res_if.
module tta_back #(
    parameter int MAX_DIMS    = tta_pkg::DIMS_MAX_DEF,
    parameter int OFFSET_BITS = tta_pkg::OFS_BITS_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_valid,
    input  logic [1+2*tta_pkg::ELEM_W+MAX_DIMS*OFFSET_BITS-1:0]   i_data,
    output logic                                                  o_pop,
    tta_res_if.source                                             o_res
);
    import tta_pkg::*;

    localparam int PB = MAX_DIMS * OFFSET_BITS;

    logic              r_valid;
    logic [DEST_W-1:0] r_dest;
    logic [ELEM_W-1:0] r_real;
    logic [ELEM_W-1:0] r_imag;
    logic              r_last;

    logic                   w_pop;
    logic [OFFSET_BITS-1:0] w_sum;

    // Unused levels arrive as zero terms; the sum wraps modulo 2^OFFSET_BITS.
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < MAX_DIMS; k++) begin
            w_sum = w_sum + i_data[k*OFFSET_BITS +: OFFSET_BITS];
        end
    end

    assign w_pop = i_valid && (!r_valid || o_res.ready);
    assign o_pop = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_pop) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_dest <= DEST_W'(w_sum);
            r_imag <= i_data[PB +: ELEM_W];
            r_real <= i_data[PB+ELEM_W +: ELEM_W];
            r_last <= i_data[PB+2*ELEM_W];
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.dest_offset = r_dest;
    assign o_res.out_real    = r_real;
    assign o_res.out_imag    = r_imag;
    assign o_res.last_elem   = r_last;

endmodule

// ===== src/tensor_transpose_address.sv =====
// Top level of the tensor transpose address generator.
// Depends on tta_pkg, tta_if, tta_cfg, tta_front, tta_queue and tta_back.
//
// Words of a column-major tensor of up to MAX_DIMS levels enter on i_elem in source
// order, one per cycle unless held off; each leaves on o_res with its column-major
// offset in the transposed tensor (modulo 2^OFFSET_BITS), its two data halves
// unchanged, and a flag on the final word, after which the source index wraps to
// zero. Sustained rate is one word per cycle while o_res is ready and no rebuild runs:
// the odometer keeps one offset term per level and updates each with one add. A word
// passes through a two-entry queue into the result register; the queue lets input
// and output stall apart.
// After reset and after every register write, a multiplier in the configuration unit
// rebuilds the level strides, one factor per cycle, and a second one in the front end
// then rebuilds the offset terms, one level per cycle; i_elem is held off until both
// are done. Register writes are accepted at any time; the source index is kept
// across them.
module tensor_transpose_address #(
    parameter int MAX_DIMS    = tta_pkg::DIMS_MAX_DEF,
    parameter int OFFSET_BITS = tta_pkg::OFS_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tta_elem_if.sink   i_elem,
    tta_cfg_if.sink    i_cfg,
    tta_res_if.source  o_res
);
    import tta_pkg::*;

    localparam int ENTRY_W = 1 + 2 * ELEM_W + MAX_DIMS * OFFSET_BITS;

    t_cfg_ctl                             w_ctl;
    logic [MAX_DIMS-1:0][EXT_W-1:0]       w_extent;
    logic [MAX_DIMS-1:0][OFFSET_BITS-1:0] w_stride;
    logic                                 w_push;
    logic [ENTRY_W-1:0]                   w_push_data;
    logic                                 w_q_ready;
    logic                                 w_q_valid;
    logic [ENTRY_W-1:0]                   w_q_data;
    logic                                 w_pop;

    tta_cfg #(
        .MAX_DIMS    (MAX_DIMS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_ctl    (w_ctl),
        .o_extent (w_extent),
        .o_stride (w_stride)
    );

    tta_front #(
        .MAX_DIMS    (MAX_DIMS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_elem    (i_elem),
        .i_ctl     (w_ctl),
        .i_extent  (w_extent),
        .i_stride  (w_stride),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_entry   (w_push_data)
    );

    tta_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_pop)
    );

    tta_back #(
        .MAX_DIMS    (MAX_DIMS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_data  (w_q_data),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule
